[src/lstk_pkg.sv]
// ----------------------------------------------------------------------------
// lstk_pkg: shared types and codes for the LIFO stack
// Mode/status codes, field widths, cell shift and controller state types.
// ----------------------------------------------------------------------------
package lstk_pkg;

	localparam int unsigned DATA_W    = 32;
	localparam int unsigned MODE_W    = 3;
	localparam int unsigned STAT_W    = 2;
	localparam int unsigned CNT_OUT_W = 5;

	// input modes
	localparam logic [MODE_W-1:0] MODE_PUSH = 3'd0;
	localparam logic [MODE_W-1:0] MODE_POP  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_INC  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SUB  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_DUMP = 3'd4;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

	// what a cell does on a clock edge
	typedef enum logic [1:0] {
		SH_HOLD,  // keep own word
		SH_DOWN,  // take the word of the neighbor nearer the top
		SH_UP     // take the word of the neighbor nearer the bottom
	} lstk_shift_t;

	// controller state
	typedef enum logic {
		S_IDLE,
		S_DUMP
	} lstk_state_t;

endpackage

[src/lstk_cell.sv]
// ----------------------------------------------------------------------------
// lstk_cell: one storage cell of the stack chain
// Holds one word and loads from either neighbor or keeps its value.
// ----------------------------------------------------------------------------
module lstk_cell
	import lstk_pkg::*;
(
	input  logic              clk,
	input  lstk_shift_t       shift,
	input  logic [DATA_W-1:0] prev_data,
	input  logic [DATA_W-1:0] next_data,
	output logic [DATA_W-1:0] data
);

	logic [DATA_W-1:0] data_q;

	// word register, no reset needed
	always_ff @(posedge clk) begin
		case (shift)
			SH_DOWN: data_q <= prev_data;
			SH_UP:   data_q <= next_data;
			default: data_q <= data_q;
		endcase
	end

	assign data = data_q;

endmodule

[src/lifo_stack_with_top_arithmetic.sv]
// ----------------------------------------------------------------------------
// lifo_stack_with_top_arithmetic: bounded LIFO of signed 32-bit words
// Push, pop, in-place top increment and subtract, and a bottom-to-top dump.
// ----------------------------------------------------------------------------
// Usage:
//   Input transactions arrive on s_* (s_tuser = mode, s_tdata = operand).
//   Results leave on m_* (m_tuser = status, m_tdata = value and entry count,
//   m_tlast marks the final result of an input transaction).
//   The stack is a chain of DEPTH cells with the top word in cell 0; push
//   and pop shift the whole chain by one cell, increment and subtract
//   rewrite cell 0.
//   Push, pop, increment, subtract and unused modes complete as they are taken and
//   the result is registered, so a new transaction is taken every cycle as
//   long as the result side keeps up.
//   Dump is taken and then rotates the full chain once through cell 0, one
//   cell per cycle while the result side keeps up; it emits the held entries,
//   bottom first, in the last steps of the rotation, one per held entry. No input
//   transaction is taken during a dump, so the next one follows only after
//   the whole rotation is done.
//   When m_tready is low, the output register holds its result and the
//   chain and the dump sequencer stop until it is taken.
//   Reset empties the stack; word storage itself is not cleared.
// ----------------------------------------------------------------------------
module lifo_stack_with_top_arithmetic
	import lstk_pkg::*;
#(
	parameter int unsigned DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] operand
	input  logic [2:0]  s_tuser,   // [2:0] mode
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] value, [36:32] entry_count, [39:37] zero
	output logic [1:0]  m_tuser,   // [1:0] status
	output logic        m_tlast
);

	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned RW = $clog2(DEPTH);

	// chain
	lstk_shift_t       cell_shift [DEPTH];
	logic [DATA_W-1:0] cell_data  [DEPTH];
	logic [DATA_W-1:0] cell0_in;
	lstk_shift_t       chain_shift;
	logic              top_wr;

	// control
	lstk_state_t       state_q, state_nxt;
	logic [CW-1:0]     count_q, count_nxt;
	logic [RW-1:0]     rot_q, rot_nxt;
	logic              out_free, acc, dump_step, dump_emit, dump_last;
	logic [CW:0]       rot_sum;

	// output register
	logic              m_valid_q;
	logic [STAT_W-1:0] m_status_q;
	logic [DATA_W-1:0] m_value_q;
	logic [CNT_OUT_W-1:0] m_count_q;
	logic              m_last_q;
	logic              load_out;
	logic [STAT_W-1:0] o_status;
	logic [DATA_W-1:0] o_value;
	logic              o_last;

	logic [MODE_W-1:0] mode;
	logic [DATA_W-1:0] operand;
	logic [DATA_W-1:0] arith_res;
	logic              is_empty, is_full;

	assign mode     = s_tuser;
	assign operand  = s_tdata;
	assign is_empty = (count_q == '0);
	assign is_full  = (count_q == CW'(DEPTH));

	// handshake
	assign out_free  = !m_valid_q || m_tready;
	assign s_tready  = (state_q == S_IDLE) && out_free;
	assign acc       = s_tvalid && s_tready;
	assign dump_step = (state_q == S_DUMP) && out_free;

	// dump: step k carries original entry DEPTH-1-k into cell 0
	assign rot_sum   = (CW + 1)'(rot_q) + (CW + 1)'(count_q);
	assign dump_emit = (rot_sum >= (CW + 1)'(DEPTH));
	assign dump_last = (rot_q == RW'(DEPTH - 1));

	// top arithmetic
	assign arith_res = (mode == MODE_INC) ? cell_data[0] + DATA_W'(1)
	                                      : cell_data[0] - operand;

	// next state
	always_comb begin
		state_nxt = state_q;
		rot_nxt   = rot_q;
		unique case (state_q)
			S_IDLE: begin
				rot_nxt = '0;
				if (acc && mode == MODE_DUMP && !is_empty) begin
					state_nxt = S_DUMP;
				end
			end
			S_DUMP: begin
				if (dump_step) begin
					rot_nxt = rot_q + RW'(1);
					if (dump_last) begin
						state_nxt = S_IDLE;
						rot_nxt   = '0;
					end
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// outputs of the controller
	always_comb begin
		chain_shift = SH_HOLD;
		top_wr      = 1'b0;
		cell0_in    = operand;
		count_nxt   = count_q;
		load_out    = 1'b0;
		o_status    = STAT_OK;
		o_value     = '0;
		o_last      = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					load_out = 1'b1;
					case (mode) inside
						MODE_PUSH: begin
							if (is_full) begin
								o_status = STAT_FULL;
							end else begin
								chain_shift = SH_DOWN;
								count_nxt   = count_q + CW'(1);
							end
						end
						MODE_POP: begin
							if (is_empty) begin
								o_status = STAT_EMPTY;
							end else begin
								chain_shift = SH_UP;
								count_nxt   = count_q - CW'(1);
								o_value     = cell_data[0];
							end
						end
						MODE_INC, MODE_SUB: begin
							if (is_empty) begin
								o_status = STAT_EMPTY;
							end else begin
								top_wr   = 1'b1;
								cell0_in = arith_res;
								o_value  = arith_res;
							end
						end
						MODE_DUMP: begin
							if (is_empty) begin
								o_status = STAT_EMPTY;
							end else begin
								load_out = 1'b0;
							end
						end
						default: ;
					endcase
				end
			end
			S_DUMP: begin
				cell0_in = cell_data[DEPTH-1];
				o_value  = cell_data[DEPTH-1];
				o_last   = dump_last;
				if (dump_step) begin
					chain_shift = SH_DOWN;
					load_out    = dump_emit;
				end
			end
			default: ;
		endcase
	end

	// cell chain, top word in cell 0
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_W-1:0] prev_d;
		logic [DATA_W-1:0] next_d;

		if (i == 0) begin : g_first
			assign prev_d = cell0_in;
			assign cell_shift[i] = top_wr ? SH_DOWN : chain_shift;
		end else begin : g_rest
			assign prev_d = cell_data[i-1];
			assign cell_shift[i] = chain_shift;
		end

		if (i == DEPTH - 1) begin : g_last
			assign next_d = cell_data[i];
		end else begin : g_inner
			assign next_d = cell_data[i+1];
		end

		lstk_cell u_cell (
			.clk       (clk),
			.shift     (cell_shift[i]),
			.prev_data (prev_d),
			.next_data (next_d),
			.data      (cell_data[i])
		);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			rot_q   <= '0;
		end else begin
			state_q <= state_nxt;
			count_q <= count_nxt;
			rot_q   <= rot_nxt;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (load_out) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			m_status_q <= o_status;
			m_value_q  <= o_value;
			m_count_q  <= CNT_OUT_W'(count_nxt);
			m_last_q   <= o_last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {3'b000, m_count_q, m_value_q};
	assign m_tuser  = m_status_q;
	assign m_tlast  = m_last_q;

	// checks
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count beyond depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUMP) |=> (count_q == $past(count_q)))
		else $error("entry count changed during dump");

	assert property (@(posedge clk) disable iff (!arst_n)
		(dump_step && dump_last) |=> (m_tvalid && m_tlast && state_q == S_IDLE))
		else $error("dump did not close with a last result");

	assert property (@(posedge clk) disable iff (!arst_n)
		(acc && mode == MODE_PUSH && !is_full) |=>
		(count_q == $past(count_q) + CW'(1)))
		else $error("push did not grow the stack");

endmodule
